FILE: src/lru_key_value_cache_core_assert.svh
// ----------------------------------------------------------------------------
// lru_key_value_cache_core_assert.svh
// Assertion macros used by the LRU cache checker.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// Same-cycle implication: cond holds whenever trig holds.
`define LKVC_ASSERT_SAME(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Next-cycle implication: cond holds in the cycle after trig.
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

    // Capacity register
    localparam int unsigned CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request and lane compare results
        logic write;  // update store and result register
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/lkvc_req_if.sv
// ----------------------------------------------------------------------------
// lkvc_req_if
// Request channel: operation kind, key and value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 31
) ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

`default_nettype wire

FILE: src/lkvc_rsp_if.sv
// ----------------------------------------------------------------------------
// lkvc_rsp_if
// Response channel: hit flag and read value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_rsp_if #(
    parameter int VALUE_BITS = 31
) ();
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

FILE: src/lkvc_cfg_if.sv
// ----------------------------------------------------------------------------
// lkvc_cfg_if
// Configuration write channel carrying the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_cfg_if import lkvc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CAP_BITS-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

FILE: src/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: accepts a request, runs the update step, owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl import lkvc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Commands
    always_comb
    begin
        cmd.load  = (state_reg == ST_IDLE) && in_valid;
        cmd.write = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.write)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register occupancy
    always_comb
    begin
        priority if (cmd.write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// lkvc_datapath
// Recency-ordered slot store with per-lane key compare, move-to-front shift
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_datapath import lkvc_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 31
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic                  in_kind,
    input  wire logic [KEY_BITS-1:0]   in_key,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CAP_BITS-1:0]   cfg_capacity,
    output logic                       out_found,
    output logic [VALUE_BITS-1:0]      out_read_value
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    // Store and control state
    logic [KEY_BITS-1:0]   slot_key_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] slot_value_reg [ENTRIES];
    logic [CNT_W-1:0]      used_count_reg, used_count_next;
    logic [CAP_BITS-1:0]   capacity_reg;

    // Captured request
    logic                  req_kind_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;
    logic [ENTRIES-1:0]    hit_vec_reg, hit_vec_next;

    // Result register
    logic                  found_reg;
    logic [VALUE_BITS-1:0] read_value_reg;

    // Update step signals
    logic                  found;
    logic [VALUE_BITS-1:0] stored;
    logic [IDX_W-1:0]      hit_idx;
    logic [CMP_W-1:0]      eff_cap;
    logic                  room;
    logic                  is_put;
    logic                  do_shift;
    logic [CNT_W-1:0]      pos;
    logic [ENTRIES-1:0]    shift_en;
    logic [VALUE_BITS-1:0] front_value;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_capacity;
        end
    end

    // Per-lane compare against valid slots (valid slots form a prefix)
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec_next[i] = (CNT_W'(i) < used_count_reg) && (slot_key_reg[i] == in_key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_kind_reg  <= in_kind;
            req_key_reg   <= in_key;
            req_value_reg <= in_value;
            hit_vec_reg   <= hit_vec_next;
        end
    end

    // Hit reduction: at most one lane matches
    always_comb
    begin
        stored  = '0;
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            stored  = stored | (slot_value_reg[i] & {VALUE_BITS{hit_vec_reg[i]}});
            hit_idx = hit_idx | (IDX_W'(i) & {IDX_W{hit_vec_reg[i]}});
        end
        found = |hit_vec_reg;
    end

    // Effective capacity, clamped to 1..ENTRIES
    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(capacity_reg);
        end
    end

    // Move-to-front position: hit slot, free slot, or least recent on evict
    always_comb
    begin
        is_put      = (req_kind_reg == KIND_PUT);
        room        = (CMP_W'(used_count_reg) < eff_cap);
        do_shift    = found || is_put;
        front_value = is_put ? req_value_reg : stored;
        priority if (found)
        begin
            pos = CNT_W'(hit_idx);
        end
        else if (room)
        begin
            pos = used_count_reg;
        end
        else
        begin
            pos = used_count_reg - CNT_W'(1);
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            shift_en[i] = cmd.write && do_shift && (CNT_W'(i) <= pos);
        end
        used_count_next = used_count_reg;
        if (cmd.write && !found && is_put && room)
        begin
            used_count_next = used_count_reg + CNT_W'(1);
        end
    end

    // Front slot takes the new entry
    always_ff @(posedge clk)
    begin
        if (shift_en[0])
        begin
            slot_key_reg[0]   <= req_key_reg;
            slot_value_reg[0] <= front_value;
        end
    end

    // Remaining slots shift back by one up to the position
    for (genvar g = 1; g < ENTRIES; g++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (shift_en[g])
            begin
                slot_key_reg[g]   <= slot_key_reg[g-1];
                slot_value_reg[g] <= slot_value_reg[g-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else
        begin
            used_count_reg <= used_count_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            found_reg      <= found;
            read_value_reg <= (found && !is_put) ? stored : '0;
        end
    end

    assign out_found      = found_reg;
    assign out_read_value = read_value_reg;

endmodule

`default_nettype wire

FILE: src/lru_key_value_cache_core.sv
// The lane compare runs in the idle state and is registered with the request on
// transfer; the move-to-front update and the result register write follow in the
// EXEC state. A new request is taken only once the update step has run.
// A full response register that is not taken stalls the update step.
// Reset (rst_n, async, active low) empties the store and sets capacity to 16.
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least recently used replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_core import lkvc_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 31
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lkvc_req_if.sink    req,
    lkvc_rsp_if.source  rsp,
    lkvc_cfg_if.sink    cfg
);

    cmd_t cmd;

    // Sequencer
    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Store, compare and result datapath
    lkvc_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_kind        (req.kind),
        .in_key         (req.key),
        .in_value       (req.value),
        .cfg_valid      (cfg.valid),
        .cfg_ready      (cfg.ready),
        .cfg_capacity   (cfg.capacity),
        .out_found      (rsp.found),
        .out_read_value (rsp.read_value)
    );

endmodule

`default_nettype wire

FILE: src/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the LRU cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_core_assert.svh"

module lkvc_checker #(
    parameter int VALUE_BITS = 31
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  req_valid,
    input wire logic                  req_ready,
    input wire logic                  rsp_valid,
    input wire logic                  rsp_ready,
    input wire logic                  rsp_found,
    input wire logic [VALUE_BITS-1:0] rsp_read_value
);

    logic req_xfer;

    assign req_xfer = req_valid && req_ready;

    // A stalled response keeps its payload
    `LKVC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_read_value), "response changed while stalled")

    // One request in flight: no transfer right after a transfer
    `LKVC_ASSERT_NEXT(a_one_inflight, clk, rst_n, req_xfer, !req_ready, "request taken while busy")

    // A new response traces back to an earlier request transfer
    `LKVC_ASSERT_SAME(a_rsp_origin, clk, rst_n, $rose(rsp_valid), $past(req_xfer, 2), "response without request")

    // Misses report a zero value
    `LKVC_ASSERT_SAME(a_miss_zero, clk, rst_n, rsp_valid && !rsp_found, rsp_read_value == '0, "nonzero value on miss")

endmodule

bind lru_key_value_cache_core lkvc_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_read_value (rsp.read_value)
);

`default_nettype wire
